>>> sv/primality_test_32bit_defines.svh
// assertion macros for the primality test block
`ifndef PRIMALITY_TEST_32BIT_DEFINES_SVH
`define PRIMALITY_TEST_32BIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ptst_pkg.sv
// types, commands and constants shared by the primality test modules
`timescale 1ns / 1ps
`default_nettype none
package ptst_pkg;

  localparam logic [31:0] TRIAL_LIMIT      = 32'd1373653;
  localparam logic [31:0] SMALL_BASE_LIMIT = 32'd9080191;
  localparam logic [2:0]  BASE_FIRST_SMALL = 3'd0;
  localparam logic [2:0]  BASE_LAST_SMALL  = 3'd1;
  localparam logic [2:0]  BASE_FIRST_LARGE = 3'd2;
  localparam logic [2:0]  BASE_LAST_LARGE  = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_CLASS, S_TCHK, S_TDIV1, S_TDIV2, S_DS, S_DSH,
    S_WB, S_WBW, S_PCHK, S_PM1, S_PM2, S_PS1, S_PS2, S_SQCHK, S_SQ1,
    S_SQ2, S_NEXT, S_RES
  } state_t;

  typedef enum logic [1:0] {DV_M, DV_BASE, DV_PROD} div_src_t;
  typedef enum logic [1:0] {DS_TPLUS, DS_TMINUS, DS_MOD} div_dsr_t;
  typedef enum logic [1:0] {MUL_AB, MUL_BB, MUL_XX} mul_sel_t;

  typedef struct packed {
    logic     load_m;
    logic     set_verdict;
    logic     verdict_val;
    logic     load_out;
    logic     k_init;
    logic     k_inc;
    logic     div_start;
    div_src_t div_src;
    div_dsr_t div_dsr;
    logic     ds_init;
    logic     ds_shift;
    logic     base_first;
    logic     base_inc;
    logic     pow_init;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     pow_step;
    logic     x_init;
    logic     x_step;
  } cmd_t;

  typedef struct packed {
    logic m_lt2;
    logic m_eq2;
    logic m_even;
    logic m_eq3;
    logic m_div3;
    logic m_lt_trial;
    logic m_lt_small;
    logic rem_zero;
    logic rem_busy;
    logic trial_go;
    logic e_even;
    logic ee_zero;
    logic ee_lsb;
    logic sq_done;
    logic x_is1;
    logic y_witness;
    logic base_last;
  } sts_t;

  function automatic logic [31:0] base_val(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'd31;
      3'd1: v = 32'd73;
      3'd2: v = 32'd2;
      3'd3: v = 32'd7;
      3'd4: v = 32'd61;
      default: v = 32'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/ptst_dp.sv
// datapath: operand registers, multiplier and serial remainder unit
`timescale 1ns / 1ps
`default_nettype none
module ptst_dp import ptst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] number,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic             prime
);

  logic [31:0] m;
  logic [7:0]  k;
  logic [31:0] e;
  logic [31:0] ee;
  logic [4:0]  s;
  logic [4:0]  i;
  logic [2:0]  base_idx;
  logic [31:0] acc;
  logic [31:0] b;
  logic [31:0] x;
  logic [63:0] prod;
  logic        verdict;

  // serial remainder unit
  logic [31:0] rem;
  logic [63:0] dq;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic [32:0] part;
  logic [32:0] diff;
  logic [31:0] rem_next;
  logic [31:0] div_in;
  logic [31:0] dsr_in;

  logic [10:0] six_k;
  logic [13:0] lin;
  logic [21:0] bound;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] m_minus1;

  // multiple of three: base-4 digit sum, then once more
  logic [5:0]  digit_sum;
  logic [3:0]  digit_sum2;

  assign six_k    = 11'(k) * 11'd6;
  assign lin      = 14'(k) * 14'd36 - 14'd12;
  assign bound    = 22'(k) * 22'(lin);
  assign m_minus1 = m - 32'd1;

  assign part     = {rem, dq[63]};
  assign diff     = part - {1'b0, dsr};
  assign rem_next = diff[32] ? part[31:0] : diff[31:0];

  always_comb begin
    digit_sum = '0;
    for (int j = 0; j < 16; j++) digit_sum = digit_sum + 6'(m[2*j +: 2]);
  end

  assign digit_sum2 = 4'(digit_sum[1:0]) + 4'(digit_sum[3:2]) + 4'(digit_sum[5:4]);

  always_comb begin
    case (cmd.div_src)
      DV_M:    div_in = m;
      DV_BASE: div_in = base_val(base_idx);
      default: div_in = m;
    endcase
    case (cmd.div_dsr)
      DS_TPLUS:  dsr_in = 32'(six_k + 11'd1);
      DS_TMINUS: dsr_in = 32'(six_k - 11'd1);
      default:   dsr_in = m;
    endcase
    case (cmd.mul_sel)
      MUL_AB: begin
        mul_a = acc;
        mul_b = b;
      end
      MUL_BB: begin
        mul_a = b;
        mul_b = b;
      end
      default: begin
        mul_a = x;
        mul_b = x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      cnt <= (cmd.div_src == DV_PROD) ? 7'd64 : 7'd32;
    end else if (cnt != 7'd0) begin
      cnt <= cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      dq  <= (cmd.div_src == DV_PROD) ? prod : {div_in, 32'd0};
      dsr <= dsr_in;
    end else if (cnt != 7'd0) begin
      rem <= rem_next;
      dq  <= {dq[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_m) m <= number;
    if (cmd.k_init) k <= 8'd1;
    else if (cmd.k_inc) k <= k + 8'd1;
    if (cmd.ds_init) begin
      e <= m_minus1;
      s <= '0;
    end else if (cmd.ds_shift) begin
      e <= {1'b0, e[31:1]};
      s <= s + 5'd1;
    end
    if (cmd.base_first) base_idx <= sts.m_lt_small ? BASE_FIRST_SMALL : BASE_FIRST_LARGE;
    else if (cmd.base_inc) base_idx <= base_idx + 3'd1;
    if (cmd.pow_init) begin
      acc <= 32'd1;
      ee  <= e;
      b   <= rem;
    end else begin
      if (cmd.acc_load) acc <= rem;
      if (cmd.pow_step) begin
        b  <= rem;
        ee <= {1'b0, ee[31:1]};
      end
    end
    if (cmd.mul_start) prod <= 64'(mul_a) * 64'(mul_b);
    if (cmd.x_init) begin
      x <= acc;
      i <= '0;
    end else if (cmd.x_step) begin
      x <= rem;
      i <= i + 5'd1;
    end
    if (cmd.set_verdict) verdict <= cmd.verdict_val;
    if (cmd.load_out) prime <= verdict;
  end

  always_comb begin
    sts.m_lt2      = (m < 32'd2);
    sts.m_eq2      = (m == 32'd2);
    sts.m_even     = ~m[0];
    sts.m_eq3      = (m == 32'd3);
    sts.m_div3     = (digit_sum2 == 4'd0) || (digit_sum2 == 4'd3) ||
                     (digit_sum2 == 4'd6) || (digit_sum2 == 4'd9);
    sts.m_lt_trial = (m < TRIAL_LIMIT);
    sts.m_lt_small = (m < SMALL_BASE_LIMIT);
    sts.rem_zero   = (rem == 32'd0);
    sts.rem_busy   = (cnt != 7'd0);
    sts.trial_go   = (32'(bound) < m);
    sts.e_even     = ~e[0];
    sts.ee_zero    = (ee == 32'd0);
    sts.ee_lsb     = ee[0];
    sts.sq_done    = (i == s);
    sts.x_is1      = (x == 32'd1);
    sts.y_witness  = (rem == 32'd1) && (x != 32'd1) && (x != m_minus1);
    sts.base_last  = (base_idx == BASE_LAST_SMALL) || (base_idx == BASE_LAST_LARGE);
  end

endmodule
`default_nettype wire

>>> sv/ptst_ctrl.sv
// controller state machine sequencing the primality test
`timescale 1ns / 1ps
`default_nettype none
`include "primality_test_32bit_defines.svh"
module ptst_ctrl import ptst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic number_valid,
  output logic      number_stall,
  output logic      prime_valid,
  input  wire logic prime_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign number_stall = (state != S_IDLE);
  assign out_free     = !prime_valid || !prime_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      prime_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) prime_valid <= 1'b1;
      else if (!prime_stall) prime_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (number_valid) begin
          cmd.load_m = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.set_verdict = 1'b1;
        if (sts.m_lt2) begin
          state_next = S_RES;
        end else if (sts.m_eq2) begin
          cmd.verdict_val = 1'b1;
          state_next      = S_RES;
        end else if (sts.m_even) begin
          state_next = S_RES;
        end else if (sts.m_div3) begin
          cmd.verdict_val = sts.m_eq3;
          state_next      = S_RES;
        end else if (sts.m_lt_trial) begin
          cmd.k_init = 1'b1;
          state_next = S_TCHK;
        end else begin
          state_next = S_DS;
        end
      end
      S_TCHK: begin
        if (sts.trial_go) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DV_M;
          cmd.div_dsr   = DS_TPLUS;
          state_next    = S_TDIV1;
        end else begin
          state_next = S_DS;
        end
      end
      S_TDIV1: begin
        if (!sts.rem_busy) begin
          if (sts.rem_zero) begin
            cmd.set_verdict = 1'b1;
            state_next      = S_RES;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DV_M;
            cmd.div_dsr   = DS_TMINUS;
            state_next    = S_TDIV2;
          end
        end
      end
      S_TDIV2: begin
        if (!sts.rem_busy) begin
          if (sts.rem_zero) begin
            cmd.set_verdict = 1'b1;
            state_next      = S_RES;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_TCHK;
          end
        end
      end
      S_DS: begin
        cmd.ds_init = 1'b1;
        state_next  = S_DSH;
      end
      S_DSH: begin
        if (sts.e_even) begin
          cmd.ds_shift = 1'b1;
        end else begin
          cmd.base_first = 1'b1;
          state_next     = S_WB;
        end
      end
      S_WB: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DV_BASE;
        cmd.div_dsr   = DS_MOD;
        state_next    = S_WBW;
      end
      S_WBW: begin
        if (!sts.rem_busy) begin
          cmd.pow_init = 1'b1;
          state_next   = sts.rem_zero ? S_NEXT : S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts.ee_zero) begin
          cmd.x_init = 1'b1;
          state_next = S_SQCHK;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = sts.ee_lsb ? MUL_AB : MUL_BB;
          state_next    = sts.ee_lsb ? S_PM1 : S_PS1;
        end
      end
      S_PM1: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DV_PROD;
        cmd.div_dsr   = DS_MOD;
        state_next    = S_PM2;
      end
      S_PM2: begin
        if (!sts.rem_busy) begin
          cmd.acc_load  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_BB;
          state_next    = S_PS1;
        end
      end
      S_PS1: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DV_PROD;
        cmd.div_dsr   = DS_MOD;
        state_next    = S_PS2;
      end
      S_PS2: begin
        if (!sts.rem_busy) begin
          cmd.pow_step = 1'b1;
          state_next   = S_PCHK;
        end
      end
      S_SQCHK: begin
        if (sts.sq_done) begin
          if (!sts.x_is1) begin
            cmd.set_verdict = 1'b1;
            state_next      = S_RES;
          end else begin
            state_next = S_NEXT;
          end
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_XX;
          state_next    = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DV_PROD;
        cmd.div_dsr   = DS_MOD;
        state_next    = S_SQ2;
      end
      S_SQ2: begin
        if (!sts.rem_busy) begin
          if (sts.y_witness) begin
            cmd.set_verdict = 1'b1;
            state_next      = S_RES;
          end else begin
            cmd.x_step = 1'b1;
            state_next = S_SQCHK;
          end
        end
      end
      S_NEXT: begin
        if (sts.base_last) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict_val = 1'b1;
          state_next      = S_RES;
        end else begin
          cmd.base_inc = 1'b1;
          state_next   = S_WB;
        end
      end
      S_RES: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `PT_ASSERT_SAME(a_div_idle, cmd.div_start, !sts.rem_busy, "remainder started while busy")
  `PT_ASSERT_SAME(a_out_free, cmd.load_out, out_free, "result overwrote an untaken word")
  `PT_ASSERT_NEXT(a_accept, number_valid && !number_stall, state == S_CLASS,
                  "accepted word not classified")

endmodule
`default_nettype wire

>>> sv/primality_test_32bit.sv
// top level of the 32-bit primality test
`timescale 1ns / 1ps
`default_nettype none
// Tests one unsigned 32-bit word for primality and returns one result bit,
// prime, per input word. Small cases (below 2, two, even, multiples of
// three) are settled directly in the classify state; a multiple of three is
// found by a base-4 digit sum. Below 1373653 the block trial-divides by 6k+1
// and 6k-1; below 9080191 it then runs Miller-Rabin with bases 31 and 73,
// above that with bases 2, 7 and 61. All other remainders come from one
// shared restoring divider that retires one quotient bit per cycle, over a
// 32-bit dividend or a 64-bit product. Latency therefore varies with the
// number: trial division costs up to two divisions per k, and each witness
// takes at most 63 modular multiplies or squares, each a multiply and then
// a division of the product. One word is processed at a time; the result
// sits in an output register so the next word is accepted while an earlier
// result waits to be taken.
module primality_test_32bit import ptst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        number_valid,
  output logic             number_stall,
  input  wire logic [31:0] number,
  output logic             prime_valid,
  input  wire logic        prime_stall,
  output logic             prime
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  ptst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_stall (number_stall),
    .prime_valid  (prime_valid),
    .prime_stall  (prime_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  ptst_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .number (number),
    .cmd    (cmd),
    .sts    (sts),
    .prime  (prime)
  );

endmodule
`default_nettype wire
